/* rtl/tjdq_pkg.sv */
// ----------------------------------------------------------------------------
// tjdq_pkg
// Types and codes shared by the typed job dispatch queue.
// ----------------------------------------------------------------------------
package tjdq_pkg;

    localparam int TAG_W   = 16;
    localparam int CLASS_W = 8;
    localparam int CNT_W   = 5;

    typedef enum logic [2:0] {
        REQ_SUBMIT   = 3'd0,
        REQ_CLAIM    = 3'd1,
        REQ_COMPLETE = 3'd2,
        REQ_RETRIEVE = 3'd3,
        REQ_RET_ALL  = 3'd4,
        REQ_FLUSH    = 3'd5
    } req_code_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_NONE    = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        L_WAIT = 2'd0,
        L_BUSY = 2'd1,
        L_DONE = 2'd2
    } list_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RALL_RD,
        S_RALL_CHK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [TAG_W-1:0]   job_tag;
        logic [CLASS_W-1:0] job_class;
        logic [CLASS_W-1:0] worker_class;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   out_tag;
        logic [CLASS_W-1:0] out_class;
        logic               last;
        logic [CNT_W-1:0]   queued_count;
        logic [CNT_W-1:0]   executing_count;
        logic [CNT_W-1:0]   completed_count;
    } rsp_t;

endpackage

/* rtl/tjdq_ram.sv */
// ----------------------------------------------------------------------------
// tjdq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tjdq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/typed_job_dispatch_queue_top.sv */
// ----------------------------------------------------------------------------
// typed_job_dispatch_queue_top
// Three ordered job lists (queued, executing, completed) behind one sequencer.
// ----------------------------------------------------------------------------
// Use: a request (s_valid/s_ready, s_data) carries submit, claim, complete,
// retrieve, retrieve-all or flush. Each request yields one result on
// m_valid/m_ready, or one per completed job for retrieve-all; m_data.last
// marks the final one. cfg_valid/cfg_ready/cfg_data writes the running bit.
// Only one request is in flight: s_ready is high only while idle.
// Submit, flush and refusals go straight to the result. Claim and complete
// scan the list one entry at a time via a read and a check state (one RAM
// read port), then close the gap, moving each later entry via a read and a
// write state. Retrieve shifts likewise; retrieve-all has a read and a
// check state per result. Counts reported are list fills after the request.
// Reset clears all fills and running; list contents need no clearing.
// A stalled receiver holds the sequencer in its output state; no request
// is taken until the last result has gone.
// ----------------------------------------------------------------------------
module typed_job_dispatch_queue_top #(
    parameter int LIST_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tjdq_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tjdq_pkg::rsp_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_data
);
    import tjdq_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int FW = $clog2(LIST_DEPTH + 1);
    localparam logic [FW-1:0] FULL = FW'(LIST_DEPTH);

    state_t             state_reg, state_next;
    list_sel_t          sel_reg, sel_next;
    logic [2:0]         op_reg, op_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [CLASS_W-1:0] wcls_reg, wcls_next;
    logic [FW-1:0]      idx_reg, idx_next, n_reg, n_next;
    logic [FW-1:0]      wfill_reg, wfill_next, bfill_reg, bfill_next, dfill_reg, dfill_next;
    logic               running_reg;
    logic [1:0]         rst_reg, rst_next;
    logic [TAG_W-1:0]   rtag_reg, rtag_next;
    logic [CLASS_W-1:0] rcls_reg, rcls_next;
    logic               rlast_reg, rlast_next;

    logic               w_we, b_we, d_we;
    logic [AW-1:0]      w_waddr, b_waddr, d_waddr, raddr;
    logic [TAG_W-1:0]   w_wtag, b_wtag, d_wtag, w_rtag, b_rtag, d_rtag, cur_tag;
    logic [CLASS_W-1:0] w_wcls, w_rcls;
    logic [FW-1:0]      cur_fill, idx_inc;
    logic               match;

    tjdq_ram #(.WIDTH(TAG_W), .DEPTH(LIST_DEPTH)) u_wait_tag (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wtag),
        .raddr(raddr), .rdata(w_rtag));
    tjdq_ram #(.WIDTH(CLASS_W), .DEPTH(LIST_DEPTH)) u_wait_cls (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wcls),
        .raddr(raddr), .rdata(w_rcls));
    tjdq_ram #(.WIDTH(TAG_W), .DEPTH(LIST_DEPTH)) u_busy_tag (
        .aclk(aclk), .we(b_we), .waddr(b_waddr), .wdata(b_wtag),
        .raddr(raddr), .rdata(b_rtag));
    tjdq_ram #(.WIDTH(TAG_W), .DEPTH(LIST_DEPTH)) u_done_tag (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(d_wtag),
        .raddr(raddr), .rdata(d_rtag));

    assign idx_inc   = idx_reg + FW'(1);
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = (state_reg == S_OUT);
    assign cfg_ready = 1'b1;

    always_comb begin
        m_data.status          = rst_reg;
        m_data.out_tag         = rtag_reg;
        m_data.out_class       = rcls_reg;
        m_data.last            = rlast_reg;
        m_data.queued_count    = CNT_W'(wfill_reg);
        m_data.executing_count = CNT_W'(bfill_reg);
        m_data.completed_count = CNT_W'(dfill_reg);
    end

    always_comb begin
        case (sel_reg)
            L_WAIT:  begin cur_tag = w_rtag; cur_fill = wfill_reg; end
            L_BUSY:  begin cur_tag = b_rtag; cur_fill = bfill_reg; end
            default: begin cur_tag = d_rtag; cur_fill = dfill_reg; end
        endcase
        case (op_reg)
            REQ_CLAIM:    match = (w_rcls & wcls_reg) != '0;
            REQ_COMPLETE: match = (b_rtag == tag_reg);
            default:      match = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            running_reg <= 1'b0;
            wfill_reg   <= '0;
            bfill_reg   <= '0;
            dfill_reg   <= '0;
        end else begin
            state_reg <= state_next;
            wfill_reg <= wfill_next;
            bfill_reg <= bfill_next;
            dfill_reg <= dfill_next;
            if (cfg_valid && cfg_ready) begin
                running_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg  <= sel_next;
        op_reg   <= op_next;
        tag_reg  <= tag_next;
        wcls_reg <= wcls_next;
        idx_reg  <= idx_next;
        n_reg    <= n_next;
        rst_reg  <= rst_next;
        rtag_reg <= rtag_next;
        rcls_reg <= rcls_next;
        rlast_reg <= rlast_next;
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        op_next    = op_reg;
        tag_next   = tag_reg;
        wcls_next  = wcls_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        wfill_next = wfill_reg;
        bfill_next = bfill_reg;
        dfill_next = dfill_reg;
        rst_next   = rst_reg;
        rtag_next  = rtag_reg;
        rcls_next  = rcls_reg;
        rlast_next = rlast_reg;
        raddr      = idx_reg[AW-1:0];
        w_we = 1'b0; w_waddr = wfill_reg[AW-1:0]; w_wtag = tag_reg; w_wcls = s_data.job_class;
        b_we = 1'b0; b_waddr = bfill_reg[AW-1:0]; b_wtag = w_rtag;
        d_we = 1'b0; d_waddr = dfill_reg[AW-1:0]; d_wtag = tag_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.req_type;
                    tag_next   = s_data.job_tag;
                    wcls_next  = s_data.worker_class;
                    idx_next   = '0;
                    rst_next   = ST_OK;
                    rtag_next  = '0;
                    rcls_next  = '0;
                    rlast_next = 1'b1;
                    state_next = S_OUT;
                    case (s_data.req_type)
                        REQ_SUBMIT: begin
                            if (!running_reg || s_data.job_tag == '0) begin
                                rst_next = ST_REFUSED;
                            end else if (wfill_reg >= FULL) begin
                                rst_next = ST_FULL;
                            end else begin
                                w_we       = 1'b1;
                                w_wtag     = s_data.job_tag;
                                wfill_next = wfill_reg + FW'(1);
                            end
                        end
                        REQ_CLAIM: begin
                            sel_next   = L_WAIT;
                            state_next = S_SCAN_RD;
                        end
                        REQ_COMPLETE: begin
                            if (s_data.job_tag == '0) begin
                                rst_next = ST_REFUSED;
                            end else begin
                                sel_next   = L_BUSY;
                                state_next = S_SCAN_RD;
                            end
                        end
                        REQ_RETRIEVE: begin
                            if (!running_reg) begin
                                rst_next = ST_REFUSED;
                            end else if (dfill_reg == '0) begin
                                rst_next = ST_NONE;
                            end else begin
                                sel_next   = L_DONE;
                                state_next = S_SCAN_RD;
                            end
                        end
                        REQ_RET_ALL: begin
                            if (!running_reg) begin
                                rst_next = ST_REFUSED;
                            end else if (dfill_reg == '0) begin
                                rst_next = ST_NONE;
                            end else begin
                                n_next     = dfill_reg;
                                dfill_next = '0;
                                state_next = S_RALL_RD;
                            end
                        end
                        REQ_FLUSH: begin
                            wfill_next = '0;
                            bfill_next = '0;
                            dfill_next = '0;
                        end
                        default: rst_next = ST_REFUSED;
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (idx_reg >= cur_fill) begin
                    rst_next   = ST_NONE;
                    state_next = S_OUT;
                end else begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!match) begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end else if (op_reg == REQ_CLAIM) begin
                    if (bfill_reg >= FULL) begin
                        rst_next   = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        b_we       = 1'b1;
                        rtag_next  = w_rtag;
                        rcls_next  = w_rcls;
                        state_next = S_SHIFT_RD;
                    end
                end else if (op_reg == REQ_COMPLETE) begin
                    if (dfill_reg >= FULL) begin
                        rst_next   = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        d_we       = 1'b1;
                        state_next = S_SHIFT_RD;
                    end
                end else begin
                    rtag_next  = d_rtag;
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                raddr = idx_inc[AW-1:0];
                if (idx_inc >= cur_fill) begin
                    state_next = S_OUT;
                    case (sel_reg)
                        L_WAIT: begin
                            wfill_next = wfill_reg - FW'(1);
                            bfill_next = bfill_reg + FW'(1);
                        end
                        L_BUSY: begin
                            bfill_next = bfill_reg - FW'(1);
                            dfill_next = dfill_reg + FW'(1);
                        end
                        default: dfill_next = dfill_reg - FW'(1);
                    endcase
                end else begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                w_waddr = idx_reg[AW-1:0];
                b_waddr = idx_reg[AW-1:0];
                d_waddr = idx_reg[AW-1:0];
                w_wtag  = cur_tag;
                w_wcls  = w_rcls;
                b_wtag  = cur_tag;
                d_wtag  = cur_tag;
                w_we    = (sel_reg == L_WAIT);
                b_we    = (sel_reg == L_BUSY);
                d_we    = (sel_reg == L_DONE);
                idx_next   = idx_inc;
                state_next = S_SHIFT_RD;
            end
            S_RALL_RD: state_next = S_RALL_CHK;
            S_RALL_CHK: begin
                rtag_next  = d_rtag;
                rlast_next = (idx_inc == n_reg);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    if (op_reg == REQ_RET_ALL && !rlast_reg) begin
                        idx_next   = idx_inc;
                        state_next = S_RALL_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wfill_reg <= FULL && bfill_reg <= FULL && dfill_reg <= FULL)
        else $error("list fill beyond depth");
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");
    a_chk_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN_CHK |-> $past(state_reg) == S_SCAN_RD)
        else $error("compare without a read");
    a_fill_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OUT |=> $stable(wfill_reg) && $stable(bfill_reg))
        else $error("fills moved while result shown");

endmodule
